// ----- hw/rtl/kct_pkg.sv -----
// Shared types and constants for the keyed count table.
// Used by the controller, the datapath and the top level.
package kct_pkg;

  localparam int KEY_W    = 16;
  localparam int PRICE_W  = 16;
  localparam int QTY_W    = 8;
  localparam int CNT_W    = 5;
  localparam int TOTAL_W  = 28;
  localparam int KIND_W   = 2;
  localparam int STATUS_W = 2;

  localparam logic [KIND_W-1:0] KIND_ADD    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

  localparam logic [STATUS_W-1:0] STS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STS_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] STS_MISSING = 2'd2;
  localparam logic [STATUS_W-1:0] STS_SAT     = 2'd3;

  localparam logic [QTY_W-1:0] QTY_MAX = 8'hFF;
  localparam logic [QTY_W-1:0] QTY_ONE = 8'd1;

  // One table row as stored in the RAM.
  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   count;
  } kct_entry_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;      // latch the input transaction, reset scan index
    logic clear;     // empty the table
    logic scan_rd;   // read row at scan index
    logic idx_inc;   // advance scan index
    logic append;    // write new row at the end
    logic bump;      // count + 1 on the hit row
    logic sat;       // hit row already at max count
    logic drop;      // count - 1 on the hit row
    logic full;      // no room for a new key
    logic missing;   // key not found on remove
    logic shift_rd;  // read row above the scan index
    logic shift_wr;  // move that row down, advance index
    logic shrink;    // one row fewer
    logic emit;      // load the result register
  } kct_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              at_end;     // scan index reached the entry count
    logic              full;       // entry count at capacity
    logic              hit;        // row read matches the key
    logic              sat;        // row read has max count
    logic              last_one;   // row read has count one
    logic              shift_end;  // no row above the scan index
    logic              out_free;   // result register can take a new result
  } kct_sts_t;

endpackage

// ----- hw/rtl/keyed_count_table_with_total.sv -----
// Keyed count table with running total. Each transaction on the input stream
// (tuser: 0 add, 1 remove, 2 clear) produces exactly one result transaction.
// Add and remove scan the stored keys one row at a time, reading each row from
// the table RAM's registered read port in ST_LOOK and comparing it in ST_CMP.
// A remove that empties a row then moves each later row down (ST_SH_CHK and
// ST_SH_WR per row) and shrinks the table. Clear and the unused kind go straight
// to ST_DONE. The input is ready in the cycle after the result is loaded; the
// load waits while the previous result has not been taken.
module keyed_count_table_with_total #(
  parameter int ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [15:0] item_id, [31:16] item_price
  input  logic [1:0]  s_axis_tuser,   // [1:0] kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata    // [1:0] status, [9:2] entry_qty,
                                      // [14:10] entry_count, [42:15] total_price
);
  import kct_pkg::*;

  kct_cmd_t            cmd;
  kct_sts_t            sts;
  logic [STATUS_W-1:0] res_status;
  logic [QTY_W-1:0]    res_qty;
  logic [CNT_W-1:0]    res_count;
  logic [TOTAL_W-1:0]  res_total;

  kct_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  kct_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .in_kind    (s_axis_tuser),
    .in_key     (s_axis_tdata[15:0]),
    .in_price   (s_axis_tdata[31:16]),
    .cmd        (cmd),
    .sts        (sts),
    .out_ready  (m_axis_tready),
    .out_valid  (m_axis_tvalid),
    .out_status (res_status),
    .out_qty    (res_qty),
    .out_count  (res_count),
    .out_total  (res_total)
  );

  assign m_axis_tdata = {5'b0, res_total, res_count, res_qty, res_status};

endmodule

// ----- hw/rtl/kct_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module kct_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/kct_ctrl.sv -----
// Sequencer for the keyed count table: scan, update, shift and result hand-off.
// Depends on kct_pkg.
module kct_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  kct_pkg::kct_sts_t sts,
  output kct_pkg::kct_cmd_t cmd
);
  import kct_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_LOOK   = 6'b000010,
    ST_CMP    = 6'b000100,
    ST_SH_CHK = 6'b001000,
    ST_SH_WR  = 6'b010000,
    ST_DONE   = 6'b100000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_LOOK;
        end
      end
      ST_LOOK: begin
        case (sts.kind)
          KIND_ADD: begin
            if (sts.at_end) begin
              if (sts.full) cmd.full = 1'b1;
              else          cmd.append = 1'b1;
              state_next = ST_DONE;
            end else begin
              cmd.scan_rd = 1'b1;
              state_next  = ST_CMP;
            end
          end
          KIND_REMOVE: begin
            if (sts.at_end) begin
              cmd.missing = 1'b1;
              state_next  = ST_DONE;
            end else begin
              cmd.scan_rd = 1'b1;
              state_next  = ST_CMP;
            end
          end
          KIND_CLEAR: begin
            cmd.clear  = 1'b1;
            state_next = ST_DONE;
          end
          default: state_next = ST_DONE;
        endcase
      end
      ST_CMP: begin
        if (!sts.hit) begin
          cmd.idx_inc = 1'b1;
          state_next  = ST_LOOK;
        end else if (sts.kind == KIND_ADD) begin
          if (sts.sat) cmd.sat = 1'b1;
          else         cmd.bump = 1'b1;
          state_next = ST_DONE;
        end else begin
          cmd.drop   = 1'b1;
          state_next = sts.last_one ? ST_SH_CHK : ST_DONE;
        end
      end
      ST_SH_CHK: begin
        if (sts.shift_end) begin
          cmd.shrink = 1'b1;
          state_next = ST_DONE;
        end else begin
          cmd.shift_rd = 1'b1;
          state_next   = ST_SH_WR;
        end
      end
      ST_SH_WR: begin
        cmd.shift_wr = 1'b1;
        state_next   = ST_SH_CHK;
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  a_accept_once: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second transaction accepted while busy");

  a_emit_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> in_ready)
    else $error("not ready after result issued");

  a_shift_pair: assert property (@(posedge clk) disable iff (rst)
    cmd.shift_rd |=> cmd.shift_wr)
    else $error("shift read without following write");

endmodule

// ----- hw/rtl/kct_dp.sv -----
// Datapath: table RAM, scan index, entry count, running total, result register.
// Depends on kct_pkg and kct_ram.
module kct_dp #(
  parameter int ENTRIES = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [kct_pkg::KIND_W-1:0]     in_kind,
  input  logic [kct_pkg::KEY_W-1:0]      in_key,
  input  logic [kct_pkg::PRICE_W-1:0]    in_price,
  input  kct_pkg::kct_cmd_t              cmd,
  output kct_pkg::kct_sts_t              sts,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic [kct_pkg::STATUS_W-1:0]   out_status,
  output logic [kct_pkg::QTY_W-1:0]      out_qty,
  output logic [kct_pkg::CNT_W-1:0]      out_count,
  output logic [kct_pkg::TOTAL_W-1:0]    out_total
);
  import kct_pkg::*;

  localparam int AW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam logic [CW-1:0] LIMIT = CW'(ENTRIES);
  localparam int EW = $bits(kct_entry_t);

  logic [KIND_W-1:0]   kind_r;
  logic [KEY_W-1:0]    key_r;
  logic [PRICE_W-1:0]  price_r;
  logic [STATUS_W-1:0] res_status;
  logic [QTY_W-1:0]    res_qty;
  logic [CW-1:0]       idx;
  logic [CW-1:0]       idx_p1;
  logic [CW-1:0]       valid_cnt;
  logic [TOTAL_W-1:0]  total;
  logic [CW+CNT_W-1:0] cnt_ext;

  logic                we;
  logic [AW-1:0]       waddr;
  logic [AW-1:0]       raddr;
  kct_entry_t          wentry;
  kct_entry_t          rentry;
  logic [EW-1:0]       rword;

  assign rentry  = kct_entry_t'(rword);
  assign idx_p1  = idx + CW'(1);
  assign cnt_ext = {{CNT_W{1'b0}}, valid_cnt};
  assign raddr   = cmd.shift_rd ? idx_p1[AW-1:0] : idx[AW-1:0];

  always_comb begin
    we     = 1'b0;
    waddr  = idx[AW-1:0];
    wentry = rentry;
    if (cmd.append) begin
      we     = 1'b1;
      waddr  = valid_cnt[AW-1:0];
      wentry = '{key: key_r, price: price_r, count: QTY_ONE};
    end else if (cmd.bump) begin
      we           = 1'b1;
      wentry.count = rentry.count + QTY_ONE;
    end else if (cmd.drop) begin
      // a count that drops to zero is removed by the shift pass instead
      we           = (rentry.count != QTY_ONE);
      wentry.count = rentry.count - QTY_ONE;
    end else if (cmd.shift_wr) begin
      we = 1'b1;
    end
  end

  kct_ram #(
    .WIDTH (EW),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wentry),
    .raddr (raddr),
    .rdata (rword)
  );

  always_comb begin
    sts           = '0;
    sts.kind      = kind_r;
    sts.at_end    = (idx >= valid_cnt);
    sts.full      = (valid_cnt >= LIMIT);
    sts.hit       = (rentry.key == key_r);
    sts.sat       = (rentry.count == QTY_MAX);
    sts.last_one  = (rentry.count == QTY_ONE);
    sts.shift_end = (idx_p1 >= valid_cnt);
    sts.out_free  = !out_valid || out_ready;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_cnt <= '0;
      total     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.clear) begin
        valid_cnt <= '0;
        total     <= '0;
      end else if (cmd.append) begin
        valid_cnt <= valid_cnt + CW'(1);
        total     <= total + TOTAL_W'(price_r);
      end else if (cmd.bump) begin
        total <= total + TOTAL_W'(rentry.price);
      end else if (cmd.drop) begin
        total <= total - TOTAL_W'(rentry.price);
      end else if (cmd.shrink) begin
        valid_cnt <= valid_cnt - CW'(1);
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r     <= in_kind;
      key_r      <= in_key;
      price_r    <= in_price;
      idx        <= '0;
      res_status <= STS_OK;
      res_qty    <= '0;
    end
    if (cmd.idx_inc || cmd.shift_wr) begin
      idx <= idx_p1;
    end
    if (cmd.append) res_qty <= QTY_ONE;
    if (cmd.bump)   res_qty <= rentry.count + QTY_ONE;
    if (cmd.drop)   res_qty <= rentry.count - QTY_ONE;
    if (cmd.sat) begin
      res_status <= STS_SAT;
      res_qty    <= QTY_MAX;
    end
    if (cmd.full)    res_status <= STS_FULL;
    if (cmd.missing) res_status <= STS_MISSING;
    if (cmd.emit) begin
      out_status <= res_status;
      out_qty    <= res_qty;
      out_count  <= cnt_ext[CNT_W-1:0];
      out_total  <= total;
    end
  end

  a_room: assert property (@(posedge clk) disable iff (rst)
    valid_cnt <= LIMIT)
    else $error("entry count beyond capacity");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> sts.out_free)
    else $error("result overwritten before taken");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.clear |=> (valid_cnt == '0 && total == '0))
    else $error("clear left state behind");

  a_append_room: assert property (@(posedge clk) disable iff (rst)
    cmd.append |-> !sts.full)
    else $error("append into a full table");

endmodule

// ----- test/tb_top.sv -----
// Self-checking bench for keyed_count_table_with_total: a directed table of
// operations, then random add/remove/clear/unused-kind traffic, checked against an
// in-bench model or typed plan results. Depends on kct_pkg and the top-level RTL.
module tb_top;
  import kct_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ENTRIES    = 16;
  localparam int IDLE_LIMIT = 2000;
  localparam int HOLD_CYC   = 400;
  localparam int DRAIN_CYC  = 100;
  localparam int RAND_ITEMS = 1000;
  localparam int POOL_MAX   = 24;
  localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;  // unused code, ignored by the block

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [QTY_W-1:0]    qty;
    logic [CNT_W-1:0]    rows;
    logic [TOTAL_W-1:0]  total;
  } table_result_t;

  typedef struct {
    logic [KIND_W-1:0]  kind;
    logic [KEY_W-1:0]   id;
    logic [KEY_W-1:0]   id_step;
    logic [PRICE_W-1:0] price;
    int                 reps;
    bit                 typed;
    table_result_t      res;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;

  keyed_count_table_with_total #(.ENTRIES(ENTRIES)) uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Bench copy of the table
  logic [KEY_W-1:0]   mdl_key[ENTRIES];
  logic [PRICE_W-1:0] mdl_price[ENTRIES];
  logic [QTY_W-1:0]   mdl_count[ENTRIES];
  int unsigned        mdl_rows = 0;
  logic [TOTAL_W-1:0] mdl_total = '0;

  table_result_t pending_results[$];
  int  errors = 0;
  bit  tx_idle = 1'b1;
  bit  rx_idle = 1'b1;
  bit  hold_req = 1'b0;
  int  idle_cycles = 0;

  initial begin
    for (int i = 0; i < ENTRIES; i++) mdl_count[i] = '0;
  end

  function automatic table_result_t apply_op(input logic [KIND_W-1:0] kind,
                                             input logic [KEY_W-1:0] id,
                                             input logic [PRICE_W-1:0] price);
    table_result_t r;
    int hit;
    int j;
    r = '0;
    r.status = STS_OK;
    hit = -1;
    for (int i = 0; i < mdl_rows; i++) begin
      if (hit < 0 && mdl_key[i] == id) hit = i;
    end
    case (kind)
      KIND_ADD: begin
        if (hit >= 0) begin
          if (mdl_count[hit] == QTY_MAX) begin
            r.status = STS_SAT;
            r.qty = QTY_MAX;
          end else begin
            mdl_count[hit] = mdl_count[hit] + 1'b1;
            mdl_total = mdl_total + TOTAL_W'(mdl_price[hit]);
            r.qty = mdl_count[hit];
          end
        end else if (mdl_rows >= ENTRIES) begin
          r.status = STS_FULL;
        end else begin
          mdl_key[mdl_rows] = id;
          mdl_price[mdl_rows] = price;
          mdl_count[mdl_rows] = QTY_ONE;
          mdl_total = mdl_total + TOTAL_W'(price);
          mdl_rows++;
          r.qty = QTY_ONE;
        end
      end
      KIND_REMOVE: begin
        if (hit < 0) begin
          r.status = STS_MISSING;
        end else if (mdl_count[hit] != '0) begin
          mdl_count[hit] = mdl_count[hit] - 1'b1;
          mdl_total = mdl_total - TOTAL_W'(mdl_price[hit]);
          r.qty = mdl_count[hit];
          if (mdl_count[hit] == '0) begin
            // close the gap; the freed top row reads as empty
            for (j = hit; j + 1 < mdl_rows; j++) begin
              mdl_key[j] = mdl_key[j+1];
              mdl_price[j] = mdl_price[j+1];
              mdl_count[j] = mdl_count[j+1];
            end
            mdl_count[j] = '0;
            mdl_rows--;
          end
        end
      end
      KIND_CLEAR: begin
        for (int i = 0; i < ENTRIES; i++) mdl_count[i] = '0;
        mdl_rows = 0;
        mdl_total = '0;
      end
      default: ;
    endcase
    r.rows = CNT_W'(mdl_rows);
    r.total = mdl_total;
    return r;
  endfunction

  // One input transaction; the expectation is queued at acceptance.
  task automatic send_op(input logic [KIND_W-1:0] kind, input logic [KEY_W-1:0] id,
                         input logic [PRICE_W-1:0] price, input bit typed,
                         input table_result_t typed_res);
    int gap;
    table_result_t pred;
    gap = tx_idle ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {price, id};
    s_axis_tuser  <= kind;
    do @(posedge clk); while (!s_axis_tready);
    pred = apply_op(kind, id, price);
    pending_results.push_back(typed ? typed_res : pred);
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic report(input string field, input logic [31:0] want, input logic [31:0] got);
    errors++;
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
  endtask

  // Result checker
  always @(posedge clk) begin
    table_result_t got;
    table_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.status = m_axis_tdata[1:0];
      got.qty    = m_axis_tdata[9:2];
      got.rows   = m_axis_tdata[14:10];
      got.total  = m_axis_tdata[42:15];
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got %h", $time, m_axis_tdata);
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status)
          report("status", 32'(want.status), 32'(got.status));
        if (got.qty !== want.qty)
          report("entry_qty", 32'(want.qty), 32'(got.qty));
        if (got.rows !== want.rows)
          report("entry_count", 32'(want.rows), 32'(got.rows));
        if (got.total !== want.total)
          report("total_price", 32'(want.total), 32'(got.total));
      end
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    int stall;
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYC) @(posedge clk);
      end
      stall = rx_idle ? $urandom_range(0, 10) : 0;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
    end
  end

  initial begin
    plan_row_t plan[19];
    logic [KEY_W-1:0] pool[POOL_MAX];
    int pool_size;
    int pick;
    logic [PRICE_W-1:0] price;
    logic [KEY_W-1:0] id;
    table_result_t none;

    none = '0;
    plan[0]  = '{KIND_REMOVE, 16'h0000, 16'h0, 16'h0000, 1, 1'b1,
                 '{STS_MISSING, 8'd0, 5'd0, 28'd0}};
    plan[1]  = '{KIND_ADD, 16'h0000, 16'h0, 16'h0000, 1, 1'b1, '{STS_OK, 8'd1, 5'd1, 28'd0}};
    plan[2]  = '{KIND_ADD, 16'hFFFF, 16'h0, 16'hFFFF, 1, 1'b1,
                 '{STS_OK, 8'd1, 5'd2, 28'hFFFF}};
    // stored price wins over the offered one
    plan[3]  = '{KIND_ADD, 16'hFFFF, 16'h0, 16'h1234, 1, 1'b1,
                 '{STS_OK, 8'd2, 5'd2, 28'h1FFFE}};
    plan[4]  = '{KIND_REMOVE, 16'hFFFF, 16'h0, 16'h0000, 1, 1'b1,
                 '{STS_OK, 8'd1, 5'd2, 28'hFFFF}};
    plan[5]  = '{KIND_REMOVE, 16'hFFFF, 16'h0, 16'h0000, 1, 1'b1,
                 '{STS_OK, 8'd0, 5'd1, 28'd0}};
    plan[6]  = '{KIND_NONE, 16'hAAAA, 16'h0, 16'h5555, 1, 1'b1, '{STS_OK, 8'd0, 5'd1, 28'd0}};
    plan[7]  = '{KIND_CLEAR, 16'h0000, 16'h0, 16'h0000, 1, 1'b1, '{STS_OK, 8'd0, 5'd0, 28'd0}};
    plan[8]  = '{KIND_ADD, 16'h0100, 16'h1, 16'hFFFF, ENTRIES, 1'b0, none};
    plan[9]  = '{KIND_ADD, 16'h0200, 16'h0, 16'h0001, 1, 1'b1,
                 '{STS_FULL, 8'd0, 5'd16, 28'hFFFF0}};
    plan[10] = '{KIND_ADD, 16'h0100, 16'h0, 16'hFFFF, 254, 1'b0, none};
    plan[11] = '{KIND_ADD, 16'h0100, 16'h0, 16'h0000, 1, 1'b1,
                 '{STS_SAT, 8'd255, 5'd16, 28'd17694450}};
    plan[12] = '{KIND_REMOVE, 16'h0107, 16'h0, 16'h0000, 1, 1'b0, none};
    plan[13] = '{KIND_REMOVE, 16'h010F, 16'h0, 16'h0000, 1, 1'b0, none};
    plan[14] = '{KIND_REMOVE, 16'h0100, 16'h0, 16'h0000, 255, 1'b0, none};
    plan[15] = '{KIND_REMOVE, 16'h0300, 16'h0, 16'h0000, 1, 1'b0, none};
    plan[16] = '{KIND_ADD, 16'h0300, 16'h0, 16'h8001, 1, 1'b0, none};
    plan[17] = '{KIND_CLEAR, 16'h0000, 16'h0, 16'h0000, 1, 1'b1, '{STS_OK, 8'd0, 5'd0, 28'd0}};
    plan[18] = '{KIND_NONE, 16'h0000, 16'h0, 16'h0000, 1, 1'b1, '{STS_OK, 8'd0, 5'd0, 28'd0}};

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[r]) begin
      for (int k = 0; k < plan[r].reps; k++) begin
        send_op(plan[r].kind, plan[r].id + plan[r].id_step * KEY_W'(k), plan[r].price,
                plan[r].typed, plan[r].res);
      end
    end
    s_axis_tvalid <= 1'b0;
    wait_drained();

    pool_size = 16;
    foreach (pool[p]) pool[p] = KEY_W'($urandom);
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % 150 == 0) begin
        tx_idle = ($urandom_range(0, 2) != 0);
        rx_idle = ($urandom_range(0, 2) != 0);
      end
      if (n == 300) hold_req = 1'b1;
      if (n == 900) begin
        s_axis_tvalid <= 1'b0;
        wait_drained();
      end
      if (n == 600) begin
        // push one key past saturation with random content
        price = PRICE_W'($urandom);
        repeat (258) send_op(KIND_ADD, pool[0], price, 1'b0, none);
      end
      pick = $urandom_range(0, 99);
      case ($urandom_range(0, 7))
        0:       price = 16'hFFFF;
        1:       price = 16'h0000;
        default: price = PRICE_W'($urandom);
      endcase
      id = pool[$urandom_range(0, pool_size - 1)];
      if (pick < 48) begin
        send_op(KIND_ADD, id, price, 1'b0, none);
      end else if (pick < 88) begin
        send_op(KIND_REMOVE, id, price, 1'b0, none);
      end else if (pick < 91) begin
        send_op(KIND_CLEAR, KEY_W'($urandom), price, 1'b0, none);
        case ($urandom_range(0, 2))
          0:       pool_size = 3;
          1:       pool_size = 16;
          default: pool_size = POOL_MAX;
        endcase
        foreach (pool[p]) pool[p] = KEY_W'($urandom);
      end else if (pick < 93) begin
        send_op(KIND_NONE, KEY_W'($urandom), price, 1'b0, none);
      end else if (pick < 97) begin
        send_op(KIND_REMOVE, KEY_W'($urandom), price, 1'b0, none);
      end else begin
        send_op(KIND_ADD, KEY_W'($urandom), price, 1'b0, none);
      end
    end
    s_axis_tvalid <= 1'b0;

    wait_drained();
    repeat (DRAIN_CYC) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
